// File: rtl/asid_rr_pkg.sv
// shared constants and request codes for the asid allocator
package asid_rr_pkg;

  localparam int NUM_IDS_DEF    = 15;
  localparam int OWNER_BITS_DEF = 8;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

endpackage

// File: rtl/asid_allocator_round_robin_steal_unit.sv
// asid allocator with lowest-free grant and round-robin steal
//
// usage
//   input channel (in_valid / in_stall) carries one request per transaction:
//   op selects allocate or release, owner_id names the requesting address
//   space, held_asid is the id being released. the output channel
//   (out_valid / out_stall) returns exactly one result transaction per request:
//   granted_asid, stolen, victim_valid, victim_owner and flush_request.
//   an accepted request waits in the input register, then the allocation
//   logic (a priority encode over the used flags plus one table read at the
//   steal rotor) feeds the result register, which raises out_valid.
//   throughput is one request per cycle while out_stall is low; the table
//   and rotor are updated as a request moves from the input register to the
//   result register, so the next request sees the new state with no bubble.
//   while the receiver holds out_stall the result register keeps its
//   transaction, the input register fills, and then in_stall is raised.
//   reset (rst, synchronous) marks every id free, sets the rotor to 1 and
//   empties both registers; there is no clearing pass.
module asid_allocator_round_robin_steal_unit
  import asid_rr_pkg::*;
#(
  parameter int NUM_IDS    = NUM_IDS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF,
  localparam int ID_BITS   = $clog2(NUM_IDS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [OWNER_BITS-1:0] owner_id,
  input  logic [ID_BITS-1:0]    held_asid,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ID_BITS-1:0]    granted_asid,
  output logic                  stolen,
  output logic                  victim_valid,
  output logic [OWNER_BITS-1:0] victim_owner,
  output logic                  flush_request
);

  // input register
  logic                  s1_valid;
  op_t                   s1_op;
  logic [OWNER_BITS-1:0] s1_owner;
  logic [ID_BITS-1:0]    s1_held;

  // allocator state: owner per id, a used flag per id, steal rotor
  logic [OWNER_BITS-1:0] owner_table [NUM_IDS:0];
  logic [NUM_IDS:1]      used;
  logic [ID_BITS-1:0]    rotor;
  logic [ID_BITS-1:0]    rotor_next;

  // handshake control
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // lowest free id, priority encode over the used flags
  logic               free_found;
  logic [ID_BITS-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_IDS; i >= 1; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = ID_BITS'(i);
      end
    end
  end

  // table write and result for the request in the input register
  logic                  wr_en;
  logic [ID_BITS-1:0]    wr_idx;
  logic [OWNER_BITS-1:0] wr_data;
  logic [ID_BITS-1:0]    res_granted;
  logic                  res_stolen;
  logic [OWNER_BITS-1:0] res_victim;
  logic                  res_flush;
  logic                  held_ok;

  assign held_ok = (s1_held != '0) && (32'(s1_held) <= 32'(NUM_IDS));

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = '0;
    wr_data     = s1_owner;
    res_granted = '0;
    res_stolen  = 1'b0;
    res_victim  = '0;
    res_flush   = 1'b0;
    rotor_next  = rotor;
    unique case (s1_op)
      OP_ALLOC: begin
        wr_en = 1'b1;
        if (free_found) begin
          wr_idx      = free_idx;
          res_granted = free_idx;
        end else begin
          // every id owned: evict the one at the rotor
          wr_idx      = rotor;
          res_granted = rotor;
          res_stolen  = 1'b1;
          res_victim  = owner_table[rotor];
          res_flush   = 1'b1;
          rotor_next  = (32'(rotor) >= 32'(NUM_IDS)) ? ID_BITS'(1) : rotor + ID_BITS'(1);
        end
      end
      OP_RELEASE: begin
        // release of id 0 or out of range leaves everything alone
        if (held_ok) begin
          wr_en     = 1'b1;
          wr_idx    = s1_held;
          wr_data   = '0;
          res_flush = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      used      <= '0;
      rotor     <= ID_BITS'(1);
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        rotor <= rotor_next;
        if (wr_en) begin
          used[wr_idx] <= (wr_data != '0);
        end
      end
    end
  end

  // payload registers and owner table
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= op_t'(op);
      s1_owner <= owner_id;
      s1_held  <= held_asid;
    end
    if (s1_fire) begin
      if (wr_en) begin
        owner_table[wr_idx] <= wr_data;
      end
      granted_asid  <= res_granted;
      stolen        <= res_stolen;
      victim_valid  <= res_stolen;
      victim_owner  <= res_victim;
      flush_request <= res_flush;
    end
  end

  // rotor never leaves 1..NUM_IDS
  a_rotor_range: assert property (@(posedge clk) disable iff (rst)
    (rotor != '0) && (32'(rotor) <= 32'(NUM_IDS)))
    else $error("steal rotor out of range");

  // rotor only moves on a steal
  a_rotor_moves_on_steal: assert property (@(posedge clk) disable iff (rst)
    (rotor != $past(rotor)) |-> $past(s1_fire && res_stolen))
    else $error("rotor moved without a steal");

  // a steal always reports a victim and flushes
  a_steal_flush: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stolen) |-> (victim_valid && flush_request))
    else $error("steal without victim or flush");

  // a release never grants an id
  a_release_no_grant: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_op == OP_RELEASE) |=> (granted_asid == '0 && !stolen))
    else $error("release produced a grant");

  // input side stalls only with a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with room");

endmodule
